/* rtl/crcfac_pkg.sv */
// ============================================================================
// crcfac_pkg
// Types, constants and the byte-wide CRC-32 update shared by the frame
// append/check block.
// ============================================================================
package crcfac_pkg;

  localparam logic [31:0] CrcPoly   = 32'h04C1_1DB7;
  localparam logic [31:0] CrcTopBit = 32'h8000_0000;
  localparam logic [31:0] CrcInit   = 32'h0000_0000;
  localparam int unsigned CrcBits   = 32;

  typedef enum logic {
    MODE_APPEND = 1'b0,
    MODE_CHECK  = 1'b1
  } mode_e;

  typedef struct packed {
    logic data_bit;
    logic frame_end;
  } in_item_t;

  typedef struct packed {
    logic out_bit;
    logic is_crc_bit;
    logic out_last;
    logic crc_error;
  } out_item_t;

  // MSB-first CRC-32 over one byte, eight shift steps unrolled
  function automatic logic [31:0] crc_byte_update(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {b, 24'h00_0000};
    for (int k = 0; k < 8; k++) begin
      if ((c & CrcTopBit) != '0) begin
        c = {c[30:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[30:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* rtl/crcfac_in_if.sv */
// ============================================================================
// crcfac_in_if
// Input channel: one frame bit per item, valid/ready handshake.
// ============================================================================
interface crcfac_in_if;
  import crcfac_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/crcfac_out_if.sv */
// ============================================================================
// crcfac_out_if
// Output channel: one result bit per item, valid/ready handshake.
// ============================================================================
interface crcfac_out_if;
  import crcfac_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/crc32_frame_append_check_top.sv */
// ============================================================================
// crc32_frame_append_check_top
// Serial CRC-32 frame appender / checker with registered output.
// ============================================================================
// Takes one frame bit per cycle and presents it from the following cycle through an
// output register; an item can enter every cycle while the output side keeps
// up. Whole bytes (first bit as MSB) update the CRC-32 (poly 0x04C11DB7,
// init 0, no final XOR) in the cycle the eighth bit arrives; a trailing
// partial byte is not covered. In append mode the final bit of a frame is
// followed by the 32 CRC bits, MSB first, shifted out of a 32-bit register
// one per cycle while the output is not stalled, so such a frame end occupies
// the output for 33 items and input is held off during the 32 CRC items. In
// check mode the final item carries crc_error when the residue is nonzero.
// Mode is sampled at the frame's final bit.
module crc32_frame_append_check_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  crcfac_in_if.sink           in_i,
  crcfac_out_if.source        out_o
);
  import crcfac_pkg::*;

  localparam int unsigned RemW = $clog2(CrcBits + 1);

  mode_e           mode_q;
  logic [31:0]     crc_q,   crc_d;
  logic [6:0]      gather_q, gather_d;
  logic [2:0]      cnt_q,   cnt_d;
  logic [31:0]     shift_q, shift_d;
  logic [RemW-1:0] rem_q,   rem_d;
  logic            ovalid_q, ovalid_d;
  out_item_t       oitem_q, oitem_d;

  logic        load;
  logic        in_fire;
  logic [7:0]  byte_w;
  logic [31:0] crc_new;

  assign load     = !ovalid_q || out_o.ready;
  assign in_i.ready = load && (rem_q == '0);
  assign in_fire  = in_i.valid && in_i.ready;
  assign out_o.valid = ovalid_q;
  assign out_o.data  = oitem_q;

  assign byte_w  = {gather_q, in_i.data.data_bit};
  assign crc_new = (cnt_q == 3'd7) ? crc_byte_update(crc_q, byte_w) : crc_q;

  always_comb begin
    crc_d    = crc_q;
    gather_d = gather_q;
    cnt_d    = cnt_q;
    shift_d  = shift_q;
    rem_d    = rem_q;
    ovalid_d = ovalid_q;
    oitem_d  = oitem_q;
    if (load) begin
      if (rem_q != '0) begin
        oitem_d.out_bit    = shift_q[31];
        oitem_d.is_crc_bit = 1'b1;
        oitem_d.out_last   = (rem_q == RemW'(1));
        oitem_d.crc_error  = 1'b0;
        ovalid_d = 1'b1;
        shift_d  = {shift_q[30:0], 1'b0};
        rem_d    = rem_q - RemW'(1);
      end else if (in_fire) begin
        ovalid_d = 1'b1;
        oitem_d.out_bit    = in_i.data.data_bit;
        oitem_d.is_crc_bit = 1'b0;
        oitem_d.out_last   = !in_i.data.frame_end || (mode_q == MODE_CHECK);
        oitem_d.crc_error  = in_i.data.frame_end && (mode_q == MODE_CHECK) &&
                             (crc_new != '0);
        if (in_i.data.frame_end) begin
          crc_d    = CrcInit;
          gather_d = '0;
          cnt_d    = '0;
          if (mode_q == MODE_APPEND) begin
            shift_d = crc_new;
            rem_d   = RemW'(CrcBits);
          end
        end else begin
          crc_d    = crc_new;
          gather_d = (cnt_q == 3'd7) ? 7'd0 : byte_w[6:0];
          cnt_d    = cnt_q + 3'd1;
        end
      end else begin
        ovalid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_APPEND;
      crc_q    <= CrcInit;
      gather_q <= '0;
      cnt_q    <= '0;
      rem_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= mode_e'(cfg_wdata_i);
      end
      crc_q    <= crc_d;
      gather_q <= gather_d;
      cnt_q    <= cnt_d;
      rem_q    <= rem_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    oitem_q <= oitem_d;
  end

endmodule

/* rtl/crcfac_checker.sv */
// ============================================================================
// crcfac_checker
// Port-level checks for the CRC-32 frame append/check block.
// ============================================================================
module crcfac_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_is_crc_i,
  input logic out_last_i,
  input logic out_err_i
);

  // stalled output item stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output item dropped while stalled");

  // a non-last data item starts the CRC trailer right away
  a_trailer_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !out_is_crc_i && !out_last_i
    |=> out_valid_i && out_is_crc_i)
    else $error("CRC trailer did not follow frame end");

  // no input taken while the trailer is pending
  a_trailer_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_is_crc_i && !out_last_i |-> !in_ready_i)
    else $error("input accepted during CRC trailer");

  // error flag only on a final data item
  a_err_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_err_i |-> out_last_i && !out_is_crc_i)
    else $error("crc_error on a non-final item");

endmodule

bind crc32_frame_append_check_top crcfac_checker u_crcfac_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_is_crc_i (out_o.data.is_crc_bit),
  .out_last_i   (out_o.data.out_last),
  .out_err_i    (out_o.data.crc_error)
);

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb - serial CRC-32 frame append/check testbench
// Feeds frames bit by bit in both modes: a directed table first, then random
// frames, most of them whole bytes, half with a correct CRC tail. Every result
// item is checked against a bit-level CRC-32 predictor kept in this file.
// ----------------------------------------------------------------------------
module tb;
  import crcfac_pkg::*;

  localparam int unsigned RandItems  = 170;
  localparam int unsigned IdleLimit  = 2000;
  localparam int unsigned HoldCycles = 80;
  localparam int unsigned MaxShown   = 10;

  typedef struct {
    mode_e       mode;
    logic        d;
    logic        fe;
    logic        known;
    logic [31:0] crc;
    logic        err;
  } row_t;

  typedef struct {
    logic        known;
    logic [31:0] crc;
    logic        err;
  } note_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we;
  logic cfg_wdata;

  crcfac_in_if  in_ch ();
  crcfac_out_if out_ch ();

  crc32_frame_append_check_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  // frame state of the predictor
  logic [31:0] run_crc;
  logic [7:0]  gather;
  logic [2:0]  nbits;
  mode_e       mode_now;

  out_item_t owed_results [$];
  note_t     typed_q [$];
  int        errs;
  int        idle_cycles;
  int        burst_left;
  logic      hold_go;
  logic      hold_done;

  // directed frames; typed CRC / flag only where obvious
  row_t plan [0:24] = '{
    '{MODE_APPEND, 1'b1, 1'b1, 1'b1, 32'h0000_0000, 1'b0},
    '{MODE_APPEND, 1'b0, 1'b1, 1'b1, 32'h0000_0000, 1'b0},
    '{MODE_APPEND, 1'b0, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
    '{MODE_APPEND, 1'b0, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
    '{MODE_APPEND, 1'b0, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
    '{MODE_APPEND, 1'b0, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
    '{MODE_APPEND, 1'b0, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
    '{MODE_APPEND, 1'b0, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
    '{MODE_APPEND, 1'b0, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
    '{MODE_APPEND, 1'b1, 1'b1, 1'b1, 32'h04C1_1DB7, 1'b0},
    '{MODE_CHECK,  1'b1, 1'b1, 1'b1, 32'h0000_0000, 1'b0},
    '{MODE_CHECK,  1'b0, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
    '{MODE_CHECK,  1'b0, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
    '{MODE_CHECK,  1'b0, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
    '{MODE_CHECK,  1'b0, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
    '{MODE_CHECK,  1'b0, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
    '{MODE_CHECK,  1'b0, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
    '{MODE_CHECK,  1'b0, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
    '{MODE_CHECK,  1'b1, 1'b1, 1'b1, 32'h0000_0000, 1'b1},
    '{MODE_CHECK,  1'b1, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
    '{MODE_CHECK,  1'b1, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
    '{MODE_CHECK,  1'b1, 1'b1, 1'b1, 32'h0000_0000, 1'b0},
    '{MODE_CHECK,  1'b0, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
    '{MODE_CHECK,  1'b1, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
    '{MODE_APPEND, 1'b1, 1'b1, 1'b0, 32'h0000_0000, 1'b0}
  };

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  function automatic logic [31:0] crc_after_byte(logic [31:0] crc, logic [7:0] byte_v);
    logic [31:0] c;
    c = crc ^ {byte_v, 24'd0};
    for (int k = 0; k < 8; k++) begin
      c = c[31] ? ({c[30:0], 1'b0} ^ 32'h04C1_1DB7) : {c[30:0], 1'b0};
    end
    return c;
  endfunction

  task automatic owe(logic b, logic crcb, logic last, logic err);
    out_item_t it;
    it.out_bit    = b;
    it.is_crc_bit = crcb;
    it.out_last   = last;
    it.crc_error  = err;
    owed_results.insert(owed_results.size(), it);
  endtask

  task automatic crc_predict_item(logic d, logic fe, note_t note);
    logic [31:0] c;
    logic        err;
    gather = {gather[6:0], d};
    if (nbits == 3'd7) begin
      run_crc = crc_after_byte(run_crc, gather);
      gather  = '0;
      nbits   = '0;
    end else begin
      nbits = nbits + 3'd1;
    end
    if (!fe) begin
      owe(d, 1'b0, 1'b1, 1'b0);
    end else begin
      if (mode_now == MODE_CHECK) begin
        err = note.known ? note.err : (run_crc != '0);
        owe(d, 1'b0, 1'b1, err);
      end else begin
        c = note.known ? note.crc : run_crc;
        owe(d, 1'b0, 1'b0, 1'b0);
        for (int k = 31; k >= 0; k--) begin
          owe(c[k], 1'b1, (k == 0), 1'b0);
        end
      end
      run_crc = '0;
      gather  = '0;
      nbits   = '0;
    end
  endtask

  // accept monitor, scoreboard, watchdog
  always @(posedge clk_i) begin
    out_item_t act;
    out_item_t exp_item;
    note_t     note;
    if (rst_ni) begin
      idle_cycles = idle_cycles + 1;
      if (in_ch.valid && in_ch.ready) begin
        idle_cycles = 0;
        note = '{known: 1'b0, crc: '0, err: 1'b0};
        if (typed_q.size() != 0) note = typed_q.pop_front();
        crc_predict_item(in_ch.data.data_bit, in_ch.data.frame_end, note);
      end
      if (out_ch.valid && out_ch.ready) begin
        idle_cycles = 0;
        act = out_ch.data;
        if (owed_results.size() == 0) begin
          errs = errs + 1;
          if (errs <= MaxShown) $display("unexpected item: bit=%b crc=%b last=%b err=%b",
                                         act.out_bit, act.is_crc_bit, act.out_last,
                                         act.crc_error);
        end else begin
          exp_item = owed_results.pop_front();
          if (act !== exp_item) begin
            errs = errs + 1;
            if (errs <= MaxShown)
              $display("mismatch: exp bit=%b crc=%b last=%b err=%b, got %b %b %b %b",
                       exp_item.out_bit, exp_item.is_crc_bit, exp_item.out_last,
                       exp_item.crc_error, act.out_bit, act.is_crc_bit, act.out_last,
                       act.crc_error);
          end
        end
      end
      if (idle_cycles >= IdleLimit) begin
        $display("tb: errors");
        $finish;
      end
    end
  end

  // receiver: random ready patterns, one long hold on request
  initial begin
    int style;
    int len;
    out_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        for (int i = 0; i < HoldCycles; i++) begin
          @(posedge clk_i);
          out_ch.ready <= 1'b0;
        end
      end else begin
        style = $urandom_range(0, 3);
        len   = $urandom_range(4, 40);
        for (int i = 0; i < len; i++) begin
          @(posedge clk_i);
          case (style)
            0, 1: begin
              out_ch.ready <= 1'b1;
            end
            2: begin
              out_ch.ready <= 1'($urandom_range(0, 1));
            end
            default: begin
              out_ch.ready <= (i % 4 == 0);
            end
          endcase
        end
      end
    end
  end

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (owed_results.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic set_mode(mode_e m);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    mode_now = m;
  endtask

  task automatic offer_bit(logic d, logic fe, logic known, logic [31:0] crc_t, logic err_t);
    note_t note;
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
    end
    burst_left = burst_left - 1;
    note.known = known;
    note.crc   = crc_t;
    note.err   = err_t;
    typed_q.insert(typed_q.size(), note);
    in_ch.valid <= 1'b1;
    in_ch.data  <= '{data_bit: d, frame_end: fe};
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  initial begin
    logic        frame_q [$];
    logic [31:0] crc_v;
    logic [7:0]  byte_v;
    int          rnd_items;
    int          kind;
    int          nbytes;
    int          split;
    int          idx;
    errs        = 0;
    idle_cycles = 0;
    burst_left  = 0;
    hold_go     = 1'b0;
    hold_done   = 1'b0;
    run_crc     = '0;
    gather      = '0;
    nbits       = '0;
    mode_now    = MODE_APPEND;
    rnd_items   = 0;
    rst_ni      <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_wdata   <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_mode(MODE_APPEND);
    foreach (plan[i]) begin
      if (plan[i].mode != mode_now) set_mode(plan[i].mode);
      offer_bit(plan[i].d, plan[i].fe, plan[i].known, plan[i].crc, plan[i].err);
    end

    while (rnd_items < RandItems) begin
      if ($urandom_range(0, 1) == 0) set_mode(mode_e'($urandom_range(0, 1)));
      if (rnd_items > 90) hold_go = 1'b1;
      frame_q.delete();
      crc_v = '0;
      kind  = $urandom_range(0, 9);
      if (kind < 8) begin
        nbytes = $urandom_range(1, 2);
        for (int b = 0; b < nbytes; b++) begin
          byte_v = 8'($urandom_range(0, 255));
          crc_v  = crc_after_byte(crc_v, byte_v);
          for (int j = 7; j >= 0; j--) frame_q.insert(frame_q.size(), byte_v[j]);
        end
        if (kind < 5 || kind == 7) begin
          for (int j = 31; j >= 0; j--) frame_q.insert(frame_q.size(), crc_v[j]);
        end
        if (kind == 7) begin
          idx = $urandom_range(0, frame_q.size() - 1);
          frame_q[idx] = ~frame_q[idx];
        end
      end else begin
        repeat ($urandom_range(1, 13)) frame_q.insert(frame_q.size(), 1'($urandom_range(0, 1)));
      end
      split = (frame_q.size() > 1 && $urandom_range(0, 5) == 0) ?
              $urandom_range(1, frame_q.size() - 1) : 0;
      foreach (frame_q[i]) begin
        if (split != 0 && i == split) begin
          set_mode((mode_now == MODE_CHECK) ? MODE_APPEND : MODE_CHECK);
        end
        offer_bit(frame_q[i], (i == frame_q.size() - 1), 1'b0, '0, 1'b0);
        rnd_items = rnd_items + 1;
      end
    end

    in_ch.valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (owed_results.size() != 0) errs = errs + 1;
    if (errs == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
